FILE: hw/rtl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property that holds at every clock edge outside reset
`define SLED_ASSERT(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// consequence that must hold in the cycle after the trigger
`define SLED_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define SLED_ASSERT(label, clk, rst, expr)
`define SLED_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: hw/rtl/sled_pkg.sv
// shared types and constants of the string literal escape decoder
package sled_pkg;

   localparam int unsigned MAX_RESULTS         = 3;
   localparam int unsigned RES_CNT_W           = $clog2(MAX_RESULTS + 1);
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   // decoder phase
   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_OPEN1 = 3'd1,
      PH_OPEN2 = 3'd2,
      PH_BODY  = 3'd3,
      PH_ESC   = 3'd4,
      PH_HEX   = 3'd5,
      PH_OCT   = 3'd6
   } sled_phase_type;

   // result kind
   typedef enum logic [1:0] {
      KIND_DATA     = 2'd0,
      KIND_END      = 2'd1,
      KIND_BAD_OPEN = 2'd2,
      KIND_UNICODE  = 2'd3
   } sled_kind_type;

   // one result transaction
   typedef struct packed {
      sled_kind_type kind;
      logic [7:0]    data;
      logic          returned;
   } sled_result_type;

   // all results caused by one input byte
   typedef struct packed {
      logic [RES_CNT_W-1:0]                count;
      sled_result_type [MAX_RESULTS-1:0]   res;
   } sled_bundle_type;

   // queue status seen by front and back
   typedef struct packed {
      logic full;
      logic empty;
   } sled_queue_status_type;

endpackage

FILE: hw/rtl/sled_front.sv
// front end: accepts raw bytes, runs the decode state and builds result bundles
`include "assert_macros.svh"

module sled_front import sled_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_in_byte,
   input  sled_queue_status_type q_status,
   output logic                  push,
   output sled_bundle_type       push_data
);

   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_X      = 8'h78;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_7      = 8'h37;
   localparam logic [7:0] CH_9      = 8'h39;
   localparam logic [7:0] CH_LA     = 8'h61;
   localparam logic [7:0] CH_LB     = 8'h62;
   localparam logic [7:0] CH_LF     = 8'h66;
   localparam logic [7:0] CH_LN     = 8'h6E;
   localparam logic [7:0] CH_LR     = 8'h72;
   localparam logic [7:0] CH_LT     = 8'h74;
   localparam logic [7:0] CH_LU     = 8'h75;
   localparam logic [7:0] CH_LV     = 8'h76;
   localparam logic [7:0] CH_UA     = 8'h41;
   localparam logic [7:0] CH_UF     = 8'h46;
   localparam logic [7:0] CH_UN     = 8'h4E;
   localparam logic [7:0] CH_UU     = 8'h55;

   // append one result to a bundle
   function automatic sled_bundle_type put_res(input sled_bundle_type b,
                                               input sled_kind_type   k,
                                               input logic [7:0]      d,
                                               input logic            r);
      sled_bundle_type nb;
      nb                      = b;
      nb.res[b.count].kind     = k;
      nb.res[b.count].data     = d;
      nb.res[b.count].returned = r;
      nb.count                = b.count + RES_CNT_W'(1);
      return nb;
   endfunction

   sled_phase_type phase_ff, phase_in;
   logic           quote_char_ff, quote_char_in;
   logic           triple_mode_ff, triple_mode_in;
   logic [1:0]     pending_quotes_ff, pending_quotes_in;
   logic [1:0]     escaped_quotes_ff, escaped_quotes_in;
   logic [1:0]     digit_count_ff, digit_count_in;
   logic [8:0]     digit_value_ff, digit_value_in;
   logic           prefix_valid_ff, prefix_valid_in;

   logic           accept;
   logic [7:0]     c;
   logic [7:0]     q;
   logic           is_q;
   logic           is_bs;
   logic           run_body;
   logic           do_finish;
   logic           is_hex;
   logic [3:0]     hex_nib;
   logic           hex_ok;
   logic           oct_ok;
   logic [8:0]     hex_value;
   logic [8:0]     oct_value;
   logic [1:0]     dc_next;
   sled_bundle_type bundle;

   // byte decode shared by next state and outputs
   assign accept   = req_valid && !req_stall;
   assign c        = req_in_byte;
   assign q        = quote_char_ff ? CH_DQUOTE : CH_SQUOTE;
   assign is_q     = (c == q);
   assign is_bs    = (c == CH_BSLASH);
   assign run_body = (phase_ff == PH_OPEN1) ? !is_q : (phase_ff == PH_BODY);

   // hex and octal digit accumulation
   assign is_hex    = c inside {[CH_0:CH_9], [CH_LA:CH_LF], [CH_UA:CH_UF]};
   assign hex_nib   = (c inside {[CH_0:CH_9]}) ? c[3:0] : (c[3:0] + 4'd9);
   assign hex_ok    = prefix_valid_ff && is_hex;
   assign oct_ok    = prefix_valid_ff && (c inside {[CH_0:CH_7]});
   assign hex_value = hex_ok ? {digit_value_ff[4:0], hex_nib} : digit_value_ff;
   assign oct_value = oct_ok ? {digit_value_ff[5:0], c[2:0]} : digit_value_ff;
   assign dc_next   = digit_count_ff + 2'd1;

   // next state
   always_comb begin
      phase_in          = phase_ff;
      quote_char_in     = quote_char_ff;
      triple_mode_in    = triple_mode_ff;
      pending_quotes_in = pending_quotes_ff;
      escaped_quotes_in = escaped_quotes_ff;
      digit_count_in    = digit_count_ff;
      digit_value_in    = digit_value_ff;
      prefix_valid_in   = prefix_valid_ff;
      do_finish         = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (c == CH_SQUOTE || c == CH_DQUOTE) begin
               quote_char_in     = (c == CH_DQUOTE);
               triple_mode_in    = 1'b0;
               pending_quotes_in = 2'd0;
               escaped_quotes_in = 2'd0;
               phase_in          = PH_OPEN1;
            end
         end
         PH_OPEN1: begin
            if (is_q) phase_in = PH_OPEN2;
         end
         PH_OPEN2: begin
            if (is_q) begin
               triple_mode_in = 1'b1;
               phase_in       = PH_BODY;
            end else begin
               do_finish = 1'b1;
            end
         end
         PH_ESC: begin
            phase_in = PH_BODY;
            if (is_q) begin
               if (triple_mode_ff) escaped_quotes_in = 2'd2;
            end else if (c == CH_X) begin
               phase_in        = PH_HEX;
               digit_count_in  = 2'd0;
               digit_value_in  = 9'd0;
               prefix_valid_in = 1'b1;
            end else if (c inside {[CH_0:CH_9]}) begin
               phase_in        = PH_OCT;
               digit_count_in  = 2'd1;
               prefix_valid_in = c inside {[CH_0:CH_7]};
               digit_value_in  = (c inside {[CH_0:CH_7]}) ? {6'd0, c[2:0]} : 9'd0;
            end
         end
         PH_HEX: begin
            digit_value_in  = hex_value;
            prefix_valid_in = hex_ok;
            digit_count_in  = dc_next;
            if (dc_next >= 2'd2) begin
               phase_in        = PH_BODY;
               digit_count_in  = 2'd0;
               digit_value_in  = 9'd0;
               prefix_valid_in = 1'b0;
            end
         end
         PH_OCT: begin
            digit_value_in  = oct_value;
            prefix_valid_in = oct_ok;
            digit_count_in  = dc_next;
            if (dc_next >= 2'd3) begin
               phase_in        = PH_BODY;
               digit_count_in  = 2'd0;
               digit_value_in  = 9'd0;
               prefix_valid_in = 1'b0;
            end
         end
         default: begin
         end
      endcase

      // literal body byte
      if (run_body) begin
         phase_in = PH_BODY;
         if (triple_mode_ff) begin
            if (is_q) begin
               if (escaped_quotes_ff != 2'd0) begin
                  escaped_quotes_in = escaped_quotes_ff - 2'd1;
               end else if (pending_quotes_ff == 2'd2) begin
                  do_finish = 1'b1;
               end else begin
                  pending_quotes_in = pending_quotes_ff + 2'd1;
               end
            end else begin
               escaped_quotes_in = 2'd0;
               pending_quotes_in = 2'd0;
               if (is_bs) phase_in = PH_ESC;
            end
         end else if (is_q) begin
            do_finish = 1'b1;
         end else if (is_bs) begin
            phase_in = PH_ESC;
         end
      end

      // closing delimiter returns to idle
      if (do_finish) begin
         phase_in          = PH_IDLE;
         quote_char_in     = 1'b0;
         triple_mode_in    = 1'b0;
         pending_quotes_in = 2'd0;
         escaped_quotes_in = 2'd0;
         digit_count_in    = 2'd0;
         digit_value_in    = 9'd0;
         prefix_valid_in   = 1'b0;
      end
   end

   // result bundle for the current byte
   always_comb begin
      bundle = '0;
      case (phase_ff)
         PH_IDLE: begin
            if (!(c == CH_SQUOTE || c == CH_DQUOTE))
               bundle = put_res(bundle, KIND_BAD_OPEN, 8'd0, 1'b1);
         end
         PH_OPEN2: begin
            if (!is_q) bundle = put_res(bundle, KIND_END, 8'd0, 1'b1);
         end
         PH_ESC: begin
            if (is_q) begin
               bundle = put_res(bundle, KIND_DATA, q, 1'b0);
            end else begin
               case (c)
                  CH_NL, CH_X: begin
                  end
                  CH_LA: bundle = put_res(bundle, KIND_DATA, 8'h07, 1'b0);
                  CH_LB: bundle = put_res(bundle, KIND_DATA, 8'h08, 1'b0);
                  CH_LF: bundle = put_res(bundle, KIND_DATA, 8'h0C, 1'b0);
                  CH_LN: bundle = put_res(bundle, KIND_DATA, 8'h0A, 1'b0);
                  CH_LR: bundle = put_res(bundle, KIND_DATA, 8'h0D, 1'b0);
                  CH_LT: bundle = put_res(bundle, KIND_DATA, 8'h09, 1'b0);
                  CH_LV: bundle = put_res(bundle, KIND_DATA, 8'h0B, 1'b0);
                  CH_UN, CH_LU, CH_UU: bundle = put_res(bundle, KIND_UNICODE, 8'd0, 1'b0);
                  default: begin
                     if (!(c inside {[CH_0:CH_9]}))
                        bundle = put_res(bundle, KIND_DATA, c, 1'b0);
                  end
               endcase
            end
         end
         PH_HEX: begin
            if (dc_next >= 2'd2) bundle = put_res(bundle, KIND_DATA, hex_value[7:0], 1'b0);
         end
         PH_OCT: begin
            if (dc_next >= 2'd3) bundle = put_res(bundle, KIND_DATA, oct_value[7:0], 1'b0);
         end
         default: begin
         end
      endcase

      // body byte: flush held quotes, then the byte itself
      if (run_body) begin
         if (triple_mode_ff) begin
            if (is_q) begin
               if (escaped_quotes_ff != 2'd0)
                  bundle = put_res(bundle, KIND_DATA, q, 1'b0);
               else if (pending_quotes_ff == 2'd2)
                  bundle = put_res(bundle, KIND_END, 8'd0, 1'b0);
            end else begin
               if (pending_quotes_ff != 2'd0) bundle = put_res(bundle, KIND_DATA, q, 1'b0);
               if (pending_quotes_ff == 2'd2) bundle = put_res(bundle, KIND_DATA, q, 1'b0);
               if (!is_bs) bundle = put_res(bundle, KIND_DATA, c, 1'b0);
            end
         end else if (is_q) begin
            bundle = put_res(bundle, KIND_END, 8'd0, 1'b0);
         end else if (!is_bs) begin
            bundle = put_res(bundle, KIND_DATA, c, 1'b0);
         end
      end
   end

   // handshake toward the queue
   assign req_stall = q_status.full;
   assign push      = accept && (bundle.count != '0);
   assign push_data = bundle;

   // decode state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_IDLE;
         quote_char_ff     <= 1'b0;
         triple_mode_ff    <= 1'b0;
         pending_quotes_ff <= 2'd0;
         escaped_quotes_ff <= 2'd0;
         digit_count_ff    <= 2'd0;
         digit_value_ff    <= 9'd0;
         prefix_valid_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff          <= phase_in;
         quote_char_ff     <= quote_char_in;
         triple_mode_ff    <= triple_mode_in;
         pending_quotes_ff <= pending_quotes_in;
         escaped_quotes_ff <= escaped_quotes_in;
         digit_count_ff    <= digit_count_in;
         digit_value_ff    <= digit_value_in;
         prefix_valid_ff   <= prefix_valid_in;
      end
   end

   // a third held quote always closes the literal
   `SLED_ASSERT(a_pend_below_three, clock, reset, pending_quotes_ff != 2'd3)
   // quote tracking only exists in triple mode
   `SLED_ASSERT(a_single_no_quotes, clock, reset, triple_mode_ff || (pending_quotes_ff == 2'd0 && escaped_quotes_ff == 2'd0))
   // octal escape sits between its first and third digit
   `SLED_ASSERT(a_oct_count, clock, reset, (phase_ff != PH_OCT) || digit_count_ff == 2'd1 || digit_count_ff == 2'd2)

endmodule

FILE: hw/rtl/sled_queue.sv
// bundle queue between the decode front and the output back end
`include "assert_macros.svh"

module sled_queue import sled_pkg::*; #(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  sled_bundle_type       push_data,
   input  logic                  pop,
   output sled_bundle_type       pop_data,
   output sled_queue_status_type status
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   sled_bundle_type  entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // pointer wrap and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      if (pop)  rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_data     = entry_ff[rd_ptr_ff];

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

   `SLED_ASSERT(a_no_overflow, clock, reset, !(push && status.full))
   `SLED_ASSERT(a_no_underflow, clock, reset, !(pop && status.empty))
   `SLED_ASSERT_NEXT(a_count_track, clock, reset, 1'b1, count_ff == $past(count_ff) + CNT_W'($past(push)) - CNT_W'($past(pop)))

endmodule

FILE: hw/rtl/sled_back.sv
// back end: holds one bundle and hands its results out one transaction at a time
`include "assert_macros.svh"

module sled_back import sled_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  sled_queue_status_type q_status,
   input  sled_bundle_type       pop_data,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_kind,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_byte_returned,
   output logic                  rsp_last
);

   logic                 valid_ff, valid_in;
   logic [RES_CNT_W-1:0] idx_ff, idx_in;
   sled_bundle_type      bundle_ff, bundle_in;
   logic                 take;
   logic                 at_last;

   assign take    = valid_ff && !rsp_stall;
   assign at_last = (idx_ff == bundle_ff.count - RES_CNT_W'(1));
   assign pop     = (!valid_ff || (take && at_last)) && !q_status.empty;

   // step through the bundle, refill from the queue after its last result
   always_comb begin
      valid_in  = valid_ff;
      idx_in    = idx_ff;
      bundle_in = bundle_ff;
      if (take && !at_last) begin
         idx_in = idx_ff + RES_CNT_W'(1);
      end else if (!valid_ff || take) begin
         valid_in = !q_status.empty;
         idx_in   = '0;
         if (!q_status.empty) bundle_in = pop_data;
      end
   end

   // outputs straight from registers
   assign rsp_valid         = valid_ff;
   assign rsp_kind          = bundle_ff.res[idx_ff].kind;
   assign rsp_out_byte      = bundle_ff.res[idx_ff].data;
   assign rsp_byte_returned = bundle_ff.res[idx_ff].returned;
   assign rsp_last          = at_last;

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   // held bundle
   always_ff @(posedge clock) begin
      bundle_ff <= bundle_in;
   end

   `SLED_ASSERT(a_idx_in_bundle, clock, reset, !valid_ff || idx_ff < bundle_ff.count)
   `SLED_ASSERT_NEXT(a_drain_to_idle, clock, reset, take && at_last && q_status.empty, !valid_ff)
   `SLED_ASSERT_NEXT(a_refill, clock, reset, !valid_ff && !q_status.empty, valid_ff)

endmodule

FILE: hw/rtl/string_literal_escape_decoder.sv
// top level of the string literal escape decoder
// Takes one source byte per cycle, from the opening quote of a string literal
// onward, and returns the decoded bytes plus end, bad-opening and unicode
// flags. A byte is taken in the cycle it is offered as long as the result
// queue (QUEUE_DEPTH bundles, default 4) has room; the decode state updates in
// that same cycle, so back-to-back bytes need no gaps. Each byte yields zero
// to three results, and results leave at one per cycle while rsp_stall is low,
// from a registered output stage; the input stalls only when the queue
// between decode and output is full.
module string_literal_escape_decoder import sled_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_returned,
   output logic       rsp_last
);

   sled_queue_status_type q_status;
   logic                  push;
   logic                  pop;
   sled_bundle_type       push_data;
   sled_bundle_type       pop_data;

   // decode front end
   sled_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .q_status    (q_status),
      .push        (push),
      .push_data   (push_data)
   );

   // bundle queue
   sled_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   // output back end
   sled_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_status          (q_status),
      .pop_data          (pop_data),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_byte_returned (rsp_byte_returned),
      .rsp_last          (rsp_last)
   );

endmodule
